/* rtl/aerb_pkg.sv */
package aerb_pkg;

  localparam int unsigned NumAxesDef = 4;
  localparam int unsigned CmdW       = 4;
  localparam int unsigned AxisW      = 2;
  localparam int unsigned DataW      = 32;
  localparam int unsigned BoardIdW   = 4;
  localparam int unsigned DacW       = 16;
  localparam int unsigned PreloadW   = 24;
  localparam int unsigned BoardIdPos = 24;
  localparam int unsigned AmpMaskPos = 8;

  localparam logic [DataW-1:0] DefaultBoardWord = 32'h4008_0000;
  localparam logic [DataW-1:0] PwrMask          = 32'h0008_0000;
  localparam logic [DataW-1:0] PwrBit           = 32'h0004_0000;
  localparam logic [DataW-1:0] RelayMask        = 32'h0002_0000;
  localparam logic [DataW-1:0] RelayBit         = 32'h0001_0000;
  localparam logic [DataW-1:0] RelayFb          = 32'h0002_0000;
  localparam logic [DataW-1:0] EnReqBit         = 32'h1000_0000;
  localparam logic [DataW-1:0] EnMaskBit        = 32'h2000_0000;
  localparam logic [DataW-1:0] ValidBit         = 32'h8000_0000;
  localparam logic [DataW-1:0] DacMask          = 32'h0000_ffff;
  localparam logic [DataW-1:0] PreloadMask      = 32'h00ff_ffff;
  localparam logic [DacW-1:0]  DacMid           = 16'h8000;

  typedef enum logic [CmdW-1:0] {
    CmdWrStatus     = 4'd0,
    CmdWrAxisCtrl   = 4'd1,
    CmdWrMotor      = 4'd2,
    CmdWrCtrl       = 4'd3,
    CmdWrPreload    = 4'd4,
    CmdRdStatus     = 4'd5,
    CmdRdMotorStat  = 4'd6,
    CmdRdDac        = 4'd7,
    CmdRdPreload    = 4'd8
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [AxisW-1:0] axis;
    logic [DataW-1:0] data_in;
  } item_t;

endpackage

/* rtl/aerb_in_if.sv */
interface aerb_in_if;
  import aerb_pkg::*;

  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [AxisW-1:0] axis;
  logic [DataW-1:0] data_in;

  modport source (output valid, output cmd, output axis, output data_in, input ready);
  modport sink (input valid, input cmd, input axis, input data_in, output ready);
endinterface

/* rtl/aerb_out_if.sv */
interface aerb_out_if;
  import aerb_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

/* rtl/aerb_cfg_if.sv */
interface aerb_cfg_if;
  import aerb_pkg::*;

  logic                valid;
  logic                ready;
  logic [BoardIdW-1:0] slot_id;

  modport source (output valid, output slot_id, input ready);
  modport sink (input valid, input slot_id, output ready);
endinterface

/* rtl/amp_enable_register_block_unit.sv */
// Register block of a four-axis motor amplifier board. Each input beat is one bus command
// (cmd, axis, data_in) and gives exactly one output beat: the read quadlet for reads, zero
// for writes. A new command is taken every cycle unless the output side stalls; the result
// passes from the input register through command decode and state update into the result
// register, and stalls on the output side back up one stage at a time. The slot id register
// is written through the cfg port, which is always ready, and should only change while no
// command is in flight. An amplifier is on only when its request, power enable and relay
// are all set; a zero status word is filled with the default board word on a status write
// or status read.
module amp_enable_register_block_unit #(
  parameter int unsigned NumAxes = aerb_pkg::NumAxesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  aerb_in_if.sink           in_i,
  aerb_out_if.source        out_o,
  aerb_cfg_if.sink          cfg_i
);
  import aerb_pkg::*;

  item_t            in_item, stage_item;
  logic             stage_valid, take, step;
  logic [DataW-1:0] result;

  assign in_item.cmd     = in_i.cmd;
  assign in_item.axis    = in_i.axis;
  assign in_item.data_in = in_i.data_in;
  assign step            = stage_valid && take;
  assign cfg_i.ready     = 1'b1;

  aerb_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .take_i  (take),
    .item_o  (stage_item)
  );

  aerb_core #(
    .NumAxes (NumAxes)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid),
    .cfg_slot_id_i (cfg_i.slot_id),
    .step_i        (step),
    .item_i        (stage_item),
    .result_o      (result)
  );

  aerb_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .data_i  (result),
    .space_o (take),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_o.read_data)
  );

endmodule

/* rtl/aerb_in_stage.sv */
module aerb_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  aerb_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            take_i,
  output aerb_pkg::item_t item_o
);
  import aerb_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

/* rtl/aerb_core.sv */
module aerb_core #(
  parameter int unsigned NumAxes = aerb_pkg::NumAxesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aerb_pkg::BoardIdW-1:0] cfg_slot_id_i,
  input  logic                          step_i,
  input  aerb_pkg::item_t               item_i,
  output logic [aerb_pkg::DataW-1:0]    result_o
);
  import aerb_pkg::*;

  logic [BoardIdW-1:0] slot_id_q;
  logic [DataW-1:0]    status_q, status_d, filled;
  logic [NumAxes-1:0]  req_q, req_d, on_q, on_d;
  logic [DacW-1:0]     dac_q [NumAxes];
  logic [DacW-1:0]     dac_d [NumAxes];
  logic [PreloadW-1:0] pre_q [NumAxes];
  logic [PreloadW-1:0] pre_d [NumAxes];
  logic [DataW-1:0]    d;

  function automatic logic [DataW-1:0] power_relay(input logic [DataW-1:0] s,
                                                    input logic [DataW-1:0] w);
    logic [DataW-1:0] r;
    r = s;
    if ((w & PwrMask) != '0) begin
      r = ((w & PwrBit) != '0) ? (r | PwrBit) : (r & ~PwrBit);
    end
    if ((w & RelayMask) != '0) begin
      r = ((w & RelayBit) != '0) ? (r | RelayBit | RelayFb) : (r & ~(RelayBit | RelayFb));
    end
    return r;
  endfunction

  function automatic logic amp_on(input logic req, input logic [DataW-1:0] s);
    return req && ((s & PwrBit) != '0) && ((s & RelayBit) != '0);
  endfunction

  assign d = item_i.data_in;

  always_comb begin
    filled   = (status_q == '0) ?
               (DefaultBoardWord | (DataW'(slot_id_q) << BoardIdPos)) : status_q;
    status_d = status_q;
    req_d    = req_q;
    on_d     = on_q;
    dac_d    = dac_q;
    pre_d    = pre_q;
    result_o = '0;
    case (item_i.cmd)
      CmdWrStatus: begin
        status_d = power_relay(filled, d);
        for (int a = 0; a < NumAxes; a++) begin
          if (d[AmpMaskPos + a]) begin
            req_d[a]    = d[0];
            status_d[a] = d[0];
          end
        end
        for (int a = 0; a < NumAxes; a++) begin
          on_d[a] = amp_on(req_d[a], status_d);
        end
      end
      CmdWrAxisCtrl, CmdWrMotor: begin
        for (int a = 0; a < NumAxes; a++) begin
          if (item_i.axis == AxisW'(a)) begin
            if (item_i.cmd == CmdWrMotor && (d & ValidBit) != '0) begin
              dac_d[a] = DacW'(d & DacMask);
            end
            if ((d & EnMaskBit) != '0) begin
              req_d[a]    = (d & EnReqBit) != '0;
              status_d[a] = (d & EnReqBit) != '0;
              on_d[a]     = amp_on(req_d[a], status_d);
            end
          end
        end
      end
      CmdWrCtrl: begin
        status_d = power_relay(status_q, d);
        for (int a = 0; a < NumAxes; a++) begin
          on_d[a] = amp_on(req_q[a], status_d);
        end
      end
      CmdWrPreload: begin
        for (int a = 0; a < NumAxes; a++) begin
          if (item_i.axis == AxisW'(a)) begin
            pre_d[a] = PreloadW'(d & PreloadMask);
          end
        end
      end
      CmdRdStatus: begin
        status_d = filled;
        result_o = filled;
      end
      CmdRdMotorStat: begin
        for (int a = 0; a < NumAxes; a++) begin
          if (item_i.axis == AxisW'(a)) begin
            result_o = (req_q[a] ? EnReqBit : '0) | (on_q[a] ? EnMaskBit : '0);
          end
        end
      end
      CmdRdDac: begin
        for (int a = 0; a < NumAxes; a++) begin
          if (item_i.axis == AxisW'(a)) begin
            result_o = DataW'(dac_q[a]);
          end
        end
      end
      CmdRdPreload: begin
        for (int a = 0; a < NumAxes; a++) begin
          if (item_i.axis == AxisW'(a)) begin
            result_o = DataW'(pre_q[a]);
          end
        end
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_id_q <= '0;
      status_q  <= '0;
      req_q     <= '0;
      on_q      <= '0;
      for (int a = 0; a < NumAxes; a++) begin
        dac_q[a] <= DacMid;
        pre_q[a] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        slot_id_q <= cfg_slot_id_i;
      end
      if (step_i) begin
        status_q <= status_d;
        req_q    <= req_d;
        on_q     <= on_d;
        dac_q    <= dac_d;
        pre_q    <= pre_d;
      end
    end
  end

  // amplifier is never on without its own request
  assert property (@(posedge clk_i) disable iff (!rst_ni) (on_q & ~req_q) == '0)
    else $error("amp on without request");

  // any amplifier on needs power and relay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (on_q != '0) |-> ((status_q & PwrBit) != '0 && (status_q & RelayBit) != '0))
    else $error("amp on without power and relay");

  // low status bits mirror the requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q[NumAxes-1:0] == req_q)
    else $error("status request mirror out of step");

  // relay feedback tracks relay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((status_q & RelayFb) != '0) == ((status_q & RelayBit) != '0))
    else $error("relay feedback mismatch");

endmodule

/* rtl/aerb_out_stage.sv */
module aerb_out_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [aerb_pkg::DataW-1:0] data_i,
  output logic                       space_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [aerb_pkg::DataW-1:0] data_o
);
  import aerb_pkg::*;

  logic             valid_q;
  logic [DataW-1:0] data_q;

  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule
